/* sv/nscf_pkg.sv */
// Shared types and constants for the NMEA sentence checksum framer.
package nscf_pkg;

    // Default and widths
    localparam int MaxLenDefault = 128;
    localparam int CountW        = 8;

    // Framing characters
    localparam logic [7:0] ChDollar = 8'h24;
    localparam logic [7:0] ChStar   = 8'h2A;

    // Head bytes are packed first byte lowest
    localparam logic [15:0] HeadGp    = 16'h5047;
    localparam logic [39:0] HeadGpgga = 40'h41_47_47_50_47;
    localparam logic [39:0] HeadGpgll = 40'h4C_4C_47_50_47;
    localparam logic [39:0] HeadGpgsa = 40'h41_53_47_50_47;
    localparam logic [39:0] HeadGpgsv = 40'h56_53_47_50_47;
    localparam logic [39:0] HeadGprmc = 40'h43_4D_52_50_47;
    localparam logic [39:0] HeadGpvtg = 40'h47_54_56_50_47;

    // Verdict codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_PREFIX   = 3'd1,
        ST_NO_SUM   = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    // Sentence type codes
    typedef enum logic [2:0] {
        TY_NONE = 3'd0,
        TY_GGA  = 3'd1,
        TY_GLL  = 3'd2,
        TY_GSA  = 3'd3,
        TY_GSV  = 3'd4,
        TY_RMC  = 3'd5,
        TY_VTG  = 3'd6
    } t_stype;

    // Sentence collected so far
    typedef struct packed {
        logic [39:0]       head;
        logic [CountW-1:0] count;
        logic [7:0]        xsum;
        logic              star;
        logic [7:0]        hex_val;
        logic              hex_digit;
        logic              hex_ended;
        logic              hex_big;
        logic              overflow;
    } t_sent;

endpackage

/* sv/nscf_accum.sv */
// Sentence accumulator: pending byte, running XOR, hex decode and head capture.
module nscf_accum #(
    parameter int MAX_LEN = nscf_pkg::MaxLenDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    output nscf_pkg::t_sent o_sent
);
    import nscf_pkg::*;

    localparam logic [CountW-1:0] MaxLenW = CountW'(MAX_LEN);

    t_sent       r_sent, n_sent;
    logic [7:0]  r_pend, n_pend;
    logic        r_pend_vld, n_pend_vld;
    logic        dig_ok;
    logic [3:0]  dig_val;

    // Hex digit decode of the pending byte
    always_comb begin
        dig_ok  = 1'b1;
        dig_val = 4'd0;
        if (r_pend >= 8'h30 && r_pend <= 8'h39) begin
            dig_val = 4'(r_pend - 8'h30);
        end else if (r_pend >= 8'h41 && r_pend <= 8'h46) begin
            dig_val = 4'(r_pend - 8'h37);
        end else if (r_pend >= 8'h61 && r_pend <= 8'h66) begin
            dig_val = 4'(r_pend - 8'h57);
        end else begin
            dig_ok = 1'b0;
        end
    end

    // Next state: '$' clears, otherwise the pending byte joins the sentence
    always_comb begin
        n_sent     = r_sent;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        if (i_take) begin
            if (i_byte == ChDollar) begin
                n_sent     = '0;
                n_pend     = '0;
                n_pend_vld = 1'b0;
            end else begin
                n_pend     = i_byte;
                n_pend_vld = 1'b1;
                if (r_pend_vld) begin
                    if (r_sent.count >= MaxLenW) begin
                        n_sent.overflow = 1'b1;
                    end else begin
                        if (r_sent.count < CountW'(5)) begin
                            n_sent.head[{r_sent.count[2:0], 3'b000} +: 8] = r_pend;
                        end
                        n_sent.count = r_sent.count + CountW'(1);
                        if (!r_sent.star) begin
                            if (r_pend == ChStar) begin
                                n_sent.star = 1'b1;
                            end else begin
                                n_sent.xsum = r_sent.xsum ^ r_pend;
                            end
                        end else if (!r_sent.hex_ended) begin
                            if (!dig_ok) begin
                                n_sent.hex_ended = 1'b1;
                            end else begin
                                if (r_sent.hex_val[7:4] != 4'd0) begin
                                    n_sent.hex_big = 1'b1;
                                end
                                n_sent.hex_val   = {r_sent.hex_val[3:0], dig_val};
                                n_sent.hex_digit = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent     <= '0;
            r_pend     <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            r_sent     <= n_sent;
            r_pend     <= n_pend;
            r_pend_vld <= n_pend_vld;
        end
    end

    assign o_sent = r_sent;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sent.count <= MaxLenW)
        else $error("sentence count past maximum length");
    a_clear_on_dollar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_byte == ChDollar) |=> (r_sent.count == '0 && !r_pend_vld))
        else $error("sentence not cleared after '$'");
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sent.overflow |-> r_sent.count == MaxLenW)
        else $error("overflow flagged with room left");

endmodule

/* sv/nmea_sentence_checksum_framer.sv */
// Top level: NMEA sentence framer with checksum verdict and output register.
// Each verdict is registered: it is on the outputs in the cycle after the closing '$' is taken.
// Throughput: one byte per cycle if o_rx_ready is high; one register stage holds sentence state.
// The input stalls, whatever the byte, while a verdict sits undelivered in the output register
// and i_ready is low; o_rx_ready is !o_valid || i_ready.
// Reset (synchronous, active low) clears the sentence state and the output valid flag.
module nmea_sentence_checksum_framer #(
    parameter int MAX_LEN = nscf_pkg::MaxLenDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_status,
    output logic [2:0] o_sentence_type,
    output logic [7:0] o_computed_checksum,
    output logic [7:0] o_received_checksum,
    output logic [7:0] o_body_length
);
    import nscf_pkg::*;

    t_sent   sent;
    logic    take, close;
    t_status vstat;
    t_stype  vtype;
    logic    r_out_vld;
    t_status r_status;
    t_stype  r_type;
    logic [7:0] r_csum, r_rsum, r_len;

    assign o_rx_ready = !r_out_vld || i_ready;
    assign take       = i_rx_valid && o_rx_ready;
    assign close      = take && (i_rx_byte == ChDollar);

    nscf_accum #(
        .MAX_LEN (MAX_LEN)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_rx_byte),
        .o_sent  (sent)
    );

    // Verdict, in priority order
    always_comb begin
        if (sent.overflow) begin
            vstat = ST_OVERFLOW;
        end else if (sent.count < CountW'(2) || sent.head[15:0] != HeadGp) begin
            vstat = ST_PREFIX;
        end else if (!sent.star || !sent.hex_digit) begin
            vstat = ST_NO_SUM;
        end else if (sent.hex_big || sent.xsum[7] || sent.hex_val != sent.xsum) begin
            vstat = ST_MISMATCH;
        end else begin
            vstat = ST_OK;
        end
    end

    // Sentence type, only for accepted sentences with a full head
    always_comb begin
        vtype = TY_NONE;
        if (vstat == ST_OK && sent.count >= CountW'(5)) begin
            case (sent.head)
                HeadGpgga: vtype = TY_GGA;
                HeadGpgll: vtype = TY_GLL;
                HeadGpgsa: vtype = TY_GSA;
                HeadGpgsv: vtype = TY_GSV;
                HeadGprmc: vtype = TY_RMC;
                HeadGpvtg: vtype = TY_VTG;
                default:   vtype = TY_NONE;
            endcase
        end
    end

    // Output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (close) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (close) begin
            r_status <= vstat;
            r_type   <= vtype;
            r_csum   <= sent.xsum;
            r_rsum   <= sent.hex_val;
            r_len    <= 8'(sent.count);
        end
    end

    assign o_valid             = r_out_vld;
    assign o_status            = r_status;
    assign o_sentence_type     = r_type;
    assign o_computed_checksum = r_csum;
    assign o_received_checksum = r_rsum;
    assign o_body_length       = r_len;

    // Checks
    a_close_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        close |=> o_valid)
        else $error("no verdict after '$'");
    a_type_only_if_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_sentence_type == TY_NONE)
        else $error("sentence type given on a failed sentence");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_body_length <= 8'(MAX_LEN))
        else $error("body length past maximum");

endmodule

/* tb/nmea_sentence_checksum_framer_tb.sv */
// Self-checking testbench for the NMEA sentence checksum framer.
module nmea_sentence_checksum_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nscf_pkg::*;

    localparam int FrameMax    = MaxLenDefault;
    localparam int RandomBytes = 1500;

    // One verdict as seen on the output ports
    typedef struct packed {
        t_status    status;
        t_stype     stype;
        logic [7:0] calc;
        logic [7:0] recv;
        logic [7:0] len;
    } t_verdict;

    // One byte queued for the input channel; pin names a typed-in verdict
    typedef struct {
        logic [7:0] b;
        int         pin;
    } t_rx_item;

    // Directed sentence: fill bytes, then text, optional checksum tail, then '$'
    typedef struct {
        string      text;
        bit         seal;
        bit         lower;
        int         fill_n;
        logic [7:0] fill_b;
        bit         pinned;
        t_verdict   want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_rx_valid = 1'b0;
    logic       o_rx_ready;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [2:0] o_status;
    logic [2:0] o_sentence_type;
    logic [7:0] o_computed_checksum;
    logic [7:0] o_received_checksum;
    logic [7:0] o_body_length;

    nmea_sentence_checksum_framer #(.MAX_LEN(FrameMax)) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_rx_valid          (i_rx_valid),
        .o_rx_ready          (o_rx_ready),
        .i_rx_byte           (i_rx_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_sentence_type     (o_sentence_type),
        .o_computed_checksum (o_computed_checksum),
        .o_received_checksum (o_received_checksum),
        .o_body_length       (o_body_length)
    );

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_rx_item   byte_q[$];
    t_verdict   verdict_q[$];
    t_row       rows[$];
    int         n_pushed   = 0;
    int         n_bytes    = 0;
    int         n_verdicts = 0;
    int         err_count  = 0;
    int         tally[5];
    int         tx_gap     = 0;
    int         rx_gap     = 0;
    int         cur_pin    = -1;
    bit         long_hold  = 1'b0;

    // Predictor state: the sentence collected so far
    logic [39:0] fr_head;
    int          fr_count;
    logic [7:0]  fr_xor;
    bit          fr_star;
    logic [7:0]  fr_hex;
    bit          fr_digit;
    bit          fr_ended;
    bit          fr_big;
    logic [7:0]  fr_pend;
    bit          fr_pend_v;
    bit          fr_ovf;

    // Near the end of the stimulus no new idle bursts start
    function automatic bit is_quiet();
        return byte_q.size() < 250;
    endfunction

    task automatic report_fail(input string msg);
        err_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_fail($sformatf("verdict %0d %s got %0h want %0h", n_verdicts, name, got,
                                  want));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'h30 + n;
        return (lower ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    task automatic push_byte(input logic [7:0] b, input int pin);
        t_rx_item it;
        it.b   = b;
        it.pin = pin;
        byte_q.push_back(it);
        n_pushed++;
    endtask

    task automatic frame_clear();
        fr_head   = '0;
        fr_count  = 0;
        fr_xor    = '0;
        fr_star   = 1'b0;
        fr_hex    = '0;
        fr_digit  = 1'b0;
        fr_ended  = 1'b0;
        fr_big    = 1'b0;
        fr_pend   = '0;
        fr_pend_v = 1'b0;
        fr_ovf    = 1'b0;
    endtask

    // A byte joins the sentence: length, head, running XOR, hex digits
    task automatic absorb_byte(input logic [7:0] b);
        int d;
        if (fr_count >= FrameMax) begin
            fr_ovf = 1'b1;
            return;
        end
        if (fr_count < 5)
            fr_head[8*fr_count +: 8] = b;
        fr_count++;
        if (!fr_star) begin
            if (b == ChStar)
                fr_star = 1'b1;
            else
                fr_xor ^= b;
            return;
        end
        if (fr_ended)
            return;
        if (b >= 8'h30 && b <= 8'h39)
            d = b - 8'h30;
        else if (b >= 8'h41 && b <= 8'h46)
            d = b - 8'h41 + 10;
        else if (b >= 8'h61 && b <= 8'h66)
            d = b - 8'h61 + 10;
        else
            d = -1;
        if (d < 0) begin
            fr_ended = 1'b1;
            return;
        end
        if (fr_hex[7:4] != 4'h0)
            fr_big = 1'b1;
        fr_hex   = {fr_hex[3:0], d[3:0]};
        fr_digit = 1'b1;
    endtask

    // Expected outcome of one accepted byte; a '$' yields a verdict
    task automatic frame_step(input logic [7:0] b, output bit got, output t_verdict v);
        got = 1'b0;
        v   = '0;
        if (b != ChDollar) begin
            if (fr_pend_v)
                absorb_byte(fr_pend);
            fr_pend   = b;
            fr_pend_v = 1'b1;
            return;
        end
        got = 1'b1;
        if (fr_ovf)
            v.status = ST_OVERFLOW;
        else if (fr_count < 2 || fr_head[15:0] != HeadGp)
            v.status = ST_PREFIX;
        else if (!fr_star || !fr_digit)
            v.status = ST_NO_SUM;
        else if (fr_big || fr_xor[7] || fr_hex != fr_xor)
            v.status = ST_MISMATCH;
        else
            v.status = ST_OK;
        v.stype = TY_NONE;
        if (v.status == ST_OK && fr_count >= 5) begin
            case (fr_head)
                HeadGpgga: v.stype = TY_GGA;
                HeadGpgll: v.stype = TY_GLL;
                HeadGpgsa: v.stype = TY_GSA;
                HeadGpgsv: v.stype = TY_GSV;
                HeadGprmc: v.stype = TY_RMC;
                HeadGpvtg: v.stype = TY_VTG;
                default:   v.stype = TY_NONE;
            endcase
        end
        v.calc = fr_xor;
        v.recv = fr_hex;
        v.len  = fr_count[7:0];
        frame_clear();
    endtask

    task automatic add_row(input string text, input bit seal, input bit lower, input int fill_n,
                           input logic [7:0] fill_b, input bit pinned, input t_verdict want);
        t_row r;
        r.text   = text;
        r.seal   = seal;
        r.lower  = lower;
        r.fill_n = fill_n;
        r.fill_b = fill_b;
        r.pinned = pinned;
        r.want   = want;
        rows.push_back(r);
    endtask

    // Random sentence: mostly well formed, some broken, some noise or overlong
    task automatic gen_sentence();
        string      tags[6];
        string      pool;
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] b;
        int         kind;
        int         n;
        int         tail;
        tags = '{"GGA", "GLL", "GSA", "GSV", "RMC", "VTG"};
        pool = ",.0123456789ABCDEFNSEWMK";
        kind = $urandom_range(0, 99);
        // line noise, any byte including '$'
        if (kind < 8) begin
            n = $urandom_range(1, 12);
            repeat (n) push_byte(8'($urandom_range(0, 255)), -1);
            return;
        end
        // body long enough to overflow, or just short of it
        if (kind < 10) begin
            n = $urandom_range(FrameMax - 3, FrameMax + 12);
            push_byte(8'h47, -1);
            push_byte(8'h50, -1);
            repeat (n) push_byte(pool[$urandom_range(0, pool.len() - 1)], -1);
            push_byte(ChDollar, -1);
            return;
        end
        // prefix and type
        if ($urandom_range(0, 9) != 0) begin
            body.push_back(8'h47);
            body.push_back(8'h50);
        end else begin
            body.push_back(8'($urandom_range(8'h41, 8'h5A)));
            body.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
        if ($urandom_range(0, 4) != 0) begin
            n = $urandom_range(0, 5);
            for (int i = 0; i < 3; i++)
                body.push_back(tags[n][i]);
        end else begin
            n = $urandom_range(0, 3);
            repeat (n) body.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
        // fields, now and then an arbitrary byte
        n = $urandom_range(0, 16);
        repeat (n) begin
            if ($urandom_range(0, 15) == 0)
                b = 8'($urandom_range(0, 255));
            else
                b = pool[$urandom_range(0, pool.len() - 1)];
            if (b == ChDollar || b == ChStar)
                b = 8'h2C;
            body.push_back(b);
        end
        sum = '0;
        foreach (body[i]) begin
            sum ^= body[i];
            push_byte(body[i], -1);
        end
        // checksum tail in one of several shapes
        tail = $urandom_range(0, 99);
        if (tail >= 78 && tail < 83) begin
            // no '*' at all
        end else begin
            push_byte(ChStar, -1);
            if (tail < 65) begin
                push_byte(hex_char(sum[7:4], 1'b0), -1);
                push_byte(hex_char(sum[3:0], 1'b0), -1);
            end else if (tail < 72) begin
                push_byte(hex_char(sum[7:4], 1'b1), -1);
                push_byte(hex_char(sum[3:0], 1'b1), -1);
            end else if (tail < 78) begin
                b = sum ^ 8'($urandom_range(1, 255));
                push_byte(hex_char(b[7:4], 1'b0), -1);
                push_byte(hex_char(b[3:0], 1'b0), -1);
            end else if (tail < 87) begin
                // '*' with no digits
            end else if (tail < 91) begin
                push_byte(hex_char(sum[3:0], 1'b0), -1);
            end else if (tail < 95) begin
                push_byte(hex_char(4'($urandom_range(0, 15)), 1'b0), -1);
                push_byte(hex_char(sum[7:4], 1'b0), -1);
                push_byte(hex_char(sum[3:0], 1'b0), -1);
            end else begin
                push_byte(hex_char(sum[7:4], 1'b0), -1);
                push_byte(hex_char(sum[3:0], 1'b0), -1);
                n = $urandom_range(1, 4);
                repeat (n) push_byte(pool[$urandom_range(0, pool.len() - 1)], -1);
            end
        end
        // line end, or a stray byte, or nothing
        n = $urandom_range(0, 9);
        if (n < 8) begin
            push_byte(8'h0D, -1);
            push_byte(8'h0A, -1);
        end else if (n == 8) begin
            push_byte(8'($urandom_range(0, 255)) == ChDollar ? 8'h0A : 8'h0D, -1);
        end
        push_byte(ChDollar, -1);
    endtask

    // Input side: present bytes, predict each accepted transaction
    always @(posedge i_clk) begin : feed
        t_rx_item it;
        t_verdict v;
        bit       got;
        bit       took;
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
            i_rx_byte  <= 8'h00;
            frame_clear();
        end else begin
            took = i_rx_valid && o_rx_ready;
            if (took) begin
                n_bytes++;
                frame_step(i_rx_byte, got, v);
                if (got) begin
                    if (cur_pin >= 0)
                        v = rows[cur_pin].want;
                    verdict_q.push_back(v);
                end
            end
            if (took || !i_rx_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_rx_valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    it = byte_q.pop_front();
                    i_rx_valid <= 1'b1;
                    i_rx_byte  <= it.b;
                    cur_pin = it.pin;
                    if (!is_quiet() && $urandom_range(0, 5) == 0)
                        tx_gap = $urandom_range(1, 11);
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each verdict transaction, stall at random
    always @(posedge i_clk) begin : drain
        t_verdict v;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_verdicts++;
                if (verdict_q.size() == 0) begin
                    report_fail($sformatf("verdict %0d with nothing expected", n_verdicts));
                end else begin
                    v = verdict_q.pop_front();
                    tally[v.status]++;
                    check_field("status", o_status, v.status);
                    check_field("sentence_type", o_sentence_type, v.stype);
                    check_field("computed_checksum", o_computed_checksum, v.calc);
                    check_field("received_checksum", o_received_checksum, v.recv);
                    check_field("body_length", o_body_length, v.len);
                end
            end
            if (long_hold) begin
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!is_quiet() && $urandom_range(0, 7) == 0)
                    rx_gap = $urandom_range(1, 11);
            end
        end
    end

    // Long receiver hold-off so the framer backs up and stalls its input
    initial begin
        while (n_bytes < 600)
            @(negedge i_clk);
        long_hold = 1'b1;
        repeat (300) @(negedge i_clk);
        long_hold = 1'b0;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timed out with %0d verdicts outstanding", verdict_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus build, reset, and end of run
    initial begin
        logic [7:0] sum;
        int         base;
        foreach (tally[i])
            tally[i] = 0;

        // directed rows; typed-in verdicts only where obvious
        add_row("", 0, 0, 0, 8'h00, 1, '{ST_PREFIX, TY_NONE, 8'h00, 8'h00, 8'd0});
        add_row("", 0, 0, 0, 8'h00, 1, '{ST_PREFIX, TY_NONE, 8'h00, 8'h00, 8'd0});
        add_row("X", 0, 0, 0, 8'h00, 1, '{ST_PREFIX, TY_NONE, 8'h00, 8'h00, 8'd0});
        add_row("", 0, 0, 2, 8'hFF, 1, '{ST_PREFIX, TY_NONE, 8'hFF, 8'h00, 8'd1});
        add_row("GPGGA,1", 1, 0, 0, 8'h00, 0, '0);
        add_row("GPGLL,2", 1, 0, 0, 8'h00, 0, '0);
        add_row("GPGSA,3", 1, 0, 0, 8'h00, 0, '0);
        add_row("GPGSV,4", 1, 0, 0, 8'h00, 0, '0);
        add_row("GPRMC,5", 1, 1, 0, 8'h00, 0, '0);
        add_row("GPVTG,6", 1, 0, 0, 8'h00, 0, '0);
        add_row("GPXYZ,7", 1, 0, 0, 8'h00, 0, '0);
        add_row("GP", 1, 0, 0, 8'h00, 0, '0);
        add_row("GNGGA,1*00\r\n", 0, 0, 0, 8'h00, 0, '0);
        add_row("GPGGA,1\r\n", 0, 0, 0, 8'h00, 0, '0);
        add_row("GPGGA,1*\r\n", 0, 0, 0, 8'h00, 0, '0);
        add_row("GPGGA*FFF\r\n", 0, 0, 0, 8'h00, 0, '0);
        add_row("GPGGA*00\r\n", 0, 0, 0, 8'h00, 0, '0);
        add_row("GP\200", 1, 0, 0, 8'h00, 0, '0);
        add_row("*00\r\n", 0, 0, 3, 8'h00, 0, '0);
        add_row("GPGGA,1*4Gxyz\r\n", 0, 0, 0, 8'h00, 0, '0);
        add_row("", 0, 0, FrameMax + 1, 8'h00, 1, '{ST_PREFIX, TY_NONE, 8'h00, 8'h00, 8'd128});
        add_row("", 0, 0, FrameMax + 3, 8'h00, 1,
                '{ST_OVERFLOW, TY_NONE, 8'h00, 8'h00, 8'd128});

        foreach (rows[r]) begin
            repeat (rows[r].fill_n) push_byte(rows[r].fill_b, -1);
            sum = '0;
            for (int i = 0; i < rows[r].text.len(); i++) begin
                push_byte(rows[r].text[i], -1);
                sum ^= rows[r].text[i];
            end
            if (rows[r].seal) begin
                push_byte(ChStar, -1);
                push_byte(hex_char(sum[7:4], rows[r].lower), -1);
                push_byte(hex_char(sum[3:0], rows[r].lower), -1);
                push_byte(8'h0D, -1);
                push_byte(8'h0A, -1);
            end
            push_byte(ChDollar, rows[r].pinned ? r : -1);
        end

        // random part
        base = n_pushed;
        while (n_pushed < base + RandomBytes)
            gen_sentence();
        push_byte(ChDollar, -1);

        // reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain
        while (byte_q.size() > 0 || i_rx_valid)
            @(negedge i_clk);
        while (verdict_q.size() > 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("Checked %0d verdicts over %0d bytes (%0d directed sentences)",
                 n_verdicts, n_bytes, rows.size());
        $display("Verdicts: ok %0d, prefix %0d, no sum %0d, mismatch %0d, overflow %0d",
                 tally[ST_OK], tally[ST_PREFIX], tally[ST_NO_SUM], tally[ST_MISMATCH],
                 tally[ST_OVERFLOW]);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* nmea_sentence_checksum_framer.f */
sv/nscf_pkg.sv
sv/nscf_accum.sv
sv/nmea_sentence_checksum_framer.sv
tb/nmea_sentence_checksum_framer_tb.sv
